// File: hw/rtl/fixed_vec3_normalizer_defines.svh
// ---------------------------------------------------------------------------
// Vector normalizer assertion macros
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef FIXED_VEC3_NORMALIZER_DEFINES_SVH
`define FIXED_VEC3_NORMALIZER_DEFINES_SVH

// same-cycle implication, off during reset
`define FVN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fvn check failed");

// next-cycle implication, off during reset
`define FVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fvn check failed");

// next-cycle implication that also spans reset
`define FVN_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fvn reset check failed");

`endif

// File: hw/rtl/fvn_pkg.sv
// ---------------------------------------------------------------------------
// Vector normalizer package
// Format constants, pipeline lengths and shared types.
// ---------------------------------------------------------------------------
package fvn_pkg;

  localparam int FRAC       = 16;
  localparam int SQRT_STEPS = 32;            // one cell per result bit
  localparam int QW         = 2 * FRAC + 1;  // reciprocal quotient bits
  localparam int DEPTH      = 3 + SQRT_STEPS + QW + 2;

  localparam logic [63:0] DIVIDEND = 64'(1) << (2 * FRAC);
  localparam logic [31:0] ONE_FX   = 32'(1) << FRAC;

  // components carried along the pipe
  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vec_t;

  // how the output vector is formed
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_SCALE
  } mode_t;

endpackage

// File: hw/rtl/fixed_vec3_normalizer.sv
// ---------------------------------------------------------------------------
// Fixed-point 3D vector normalizer
// Norm and unit vector of a signed fixed-point vector, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one vector per item, tdata = {vec_z, vec_y, vec_x}, x lowest.
//   out_* : one result per item, tdata = {length, unit_z, unit_y, unit_x}.
//   cfg_* : wide_sum bit; write only while the pipe is empty.
// Throughput: one item per cycle while out_tready does not stall the pipe.
// Pipe: input, square, sum stages, a row of 32 square-root cells, a row of
//   2*FRAC+1 divider cells forming the reciprocal, a multiply stage and the
//   output register.
// The whole row advances together; when the receiver holds out_tready low
//   with a result waiting, in_tready drops and the pipe freezes. While the
//   output stage is empty the row keeps advancing.
// Reset clears all valid bits and sets wide_sum to 0; both ready outputs
//   are low during reset.
// ---------------------------------------------------------------------------
module fixed_vec3_normalizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,     // wide_sum
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,     // vec_x, vec_y, vec_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata     // unit_x, unit_y, unit_z, length
);
  import fvn_pkg::*;

  logic             wide_sum;
  logic             adv;
  logic [DEPTH-1:0] vld;

  vec_t        vec_a, vec_b, vec_c;
  logic [31:0] mag_x, mag_y, mag_z;
  logic [63:0] sqp_x, sqp_y, sqp_z;
  logic [63:0] sq_x, sq_y, sq_z, sum;

  logic [63:0] sn  [SQRT_STEPS+1];
  logic [63:0] sr  [SQRT_STEPS+1];
  vec_t        sv  [SQRT_STEPS+1];

  logic [31:0]   dden [QW+1];
  logic [31:0]   drem [QW+1];
  logic [QW-1:0] dq   [QW+1];
  logic [31:0]   dnrm [QW+1];
  vec_t          dv   [QW+1];

  logic [31:0]        norm0;
  logic [63:0]        qx;
  logic [31:0]        r32;
  logic signed [63:0] px, py, pz;
  mode_t              mode_m;
  logic [31:0]        norm_m;
  vec_t               vec_m;
  logic [127:0]       out_data;

  assign adv       = !vld[DEPTH-1] || out_tready;
  assign in_tready = adv && !rst;
  assign cfg_ready = !rst;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_sum <= 1'b0;
    end else if (cfg_valid) begin
      wide_sum <= cfg_data;
    end
  end

  // valid row
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_tvalid};
    end
  end

  // component magnitudes and full 32x32 squares
  assign mag_x = vec_a.x[31] ? (~vec_a.x + 32'd1) : vec_a.x;
  assign mag_y = vec_a.y[31] ? (~vec_a.y + 32'd1) : vec_a.y;
  assign mag_z = vec_a.z[31] ? (~vec_a.z + 32'd1) : vec_a.z;
  assign sqp_x = mag_x * mag_x;
  assign sqp_y = mag_y * mag_y;
  assign sqp_z = mag_z * mag_z;

  // input, square and sum stages
  always_ff @(posedge clk) begin
    if (adv) begin
      vec_a <= vec_t'(in_tdata);
      sq_x  <= sqp_x >> FRAC;
      sq_y  <= sqp_y >> FRAC;
      sq_z  <= sqp_z >> FRAC;
      vec_b <= vec_a;
      sum   <= wide_sum ? (sq_x + sq_y + sq_z) : {32'd0, 32'(sq_x + sq_y + sq_z)};
      vec_c <= vec_b;
    end
  end

  // square root row
  assign sn[0] = sum;
  assign sr[0] = '0;
  assign sv[0] = vec_c;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    fvn_sqrt_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .step_bit(64'(1) << (62 - 2 * i)),
      .n_in    (sn[i]),
      .res_in  (sr[i]),
      .vec_in  (sv[i]),
      .n_out   (sn[i+1]),
      .res_out (sr[i+1]),
      .vec_out (sv[i+1])
    );
  end

  // reciprocal row: (1 << 2*FRAC) / |norm|
  assign norm0   = 32'(sr[SQRT_STEPS] << (FRAC / 2));
  assign dden[0] = norm0[31] ? -norm0 : norm0;
  assign drem[0] = '0;
  assign dq[0]   = '0;
  assign dnrm[0] = norm0;
  assign dv[0]   = sv[SQRT_STEPS];

  for (genvar j = 0; j < QW; j++) begin : g_div
    fvn_div_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .num_bit (DIVIDEND[QW-1-j]),
      .den_in  (dden[j]),
      .rem_in  (drem[j]),
      .q_in    (dq[j]),
      .norm_in (dnrm[j]),
      .vec_in  (dv[j]),
      .den_out (dden[j+1]),
      .rem_out (drem[j+1]),
      .q_out   (dq[j+1]),
      .norm_out(dnrm[j+1]),
      .vec_out (dv[j+1])
    );
  end

  // signed reciprocal, low 32 bits
  assign qx  = 64'(dq[QW]);
  assign r32 = dnrm[QW][31] ? -qx[31:0] : qx[31:0];

  // multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      px     <= $signed(dv[QW].x) * $signed(r32);
      py     <= $signed(dv[QW].y) * $signed(r32);
      pz     <= $signed(dv[QW].z) * $signed(r32);
      norm_m <= dnrm[QW];
      vec_m  <= dv[QW];
      if (dnrm[QW] == '0) begin
        mode_m <= MODE_ZERO;
      end else if (dnrm[QW] == ONE_FX) begin
        mode_m <= MODE_PASS;
      end else begin
        mode_m <= MODE_SCALE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (mode_m)
        MODE_ZERO:  out_data <= {norm_m, 96'd0};
        MODE_PASS:  out_data <= {norm_m, vec_m.z, vec_m.y, vec_m.x};
        MODE_SCALE: out_data <= {norm_m, 32'(pz >>> FRAC), 32'(py >>> FRAC),
                                 32'(px >>> FRAC)};
        default:    out_data <= {norm_m, 96'd0};
      endcase
    end
  end

  assign out_tvalid = vld[DEPTH-1];
  assign out_tdata  = out_data;

endmodule

// File: hw/rtl/fvn_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One digit-pair step of the integer square root, registered.
// ---------------------------------------------------------------------------
module fvn_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   step_bit,
  input  logic [63:0]   n_in,
  input  logic [63:0]   res_in,
  input  fvn_pkg::vec_t vec_in,
  output logic [63:0]   n_out,
  output logic [63:0]   res_out,
  output fvn_pkg::vec_t vec_out
);
  import fvn_pkg::*;

  logic [63:0] trial;
  logic        take;

  assign trial = res_in + step_bit;
  assign take  = (n_in >= trial);

  // trial subtract, shift result
  always_ff @(posedge clk) begin
    if (en) begin
      n_out   <= take ? (n_in - trial) : n_in;
      res_out <= take ? ((res_in >> 1) + step_bit) : (res_in >> 1);
      vec_out <= vec_in;
    end
  end

endmodule

// File: hw/rtl/fvn_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One restoring-division step of the reciprocal, registered.
// ---------------------------------------------------------------------------
module fvn_div_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     num_bit,
  input  logic [31:0]              den_in,
  input  logic [31:0]              rem_in,
  input  logic [fvn_pkg::QW-1:0]   q_in,
  input  logic [31:0]              norm_in,
  input  fvn_pkg::vec_t            vec_in,
  output logic [31:0]              den_out,
  output logic [31:0]              rem_out,
  output logic [fvn_pkg::QW-1:0]   q_out,
  output logic [31:0]              norm_out,
  output fvn_pkg::vec_t            vec_out
);
  import fvn_pkg::*;

  logic [32:0] part;
  logic        take;

  assign part = {rem_in, num_bit};
  assign take = (part >= {1'b0, den_in});

  // shift in next dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? 32'(part - {1'b0, den_in}) : part[31:0];
      q_out    <= {q_in[QW-2:0], take};
      den_out  <= den_in;
      norm_out <= norm_in;
      vec_out  <= vec_in;
    end
  end

endmodule

// File: hw/rtl/fvn_checker.sv
// ---------------------------------------------------------------------------
// Vector normalizer port checker
// Handshake and flow checks seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "fixed_vec3_normalizer_defines.svh"

module fvn_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // a stalled result holds
  `FVN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // reset empties the pipe
  `FVN_ASSERT_RST(a_rst_empty, rst, !out_tvalid)
  // an empty output stage never blocks input
  `FVN_ASSERT_IMP(a_ready_idle, !out_tvalid, in_tready)
  // a taken result frees the pipe in the same cycle
  `FVN_ASSERT_IMP(a_ready_take, out_tvalid && out_tready, in_tready)

endmodule

bind fixed_vec3_normalizer fvn_checker u_fvn_checker (.*);

// File: dv/tb_fixed_vec3_normalizer.sv
// ---------------------------------------------------------------------------
// Vector normalizer testbench
// Streams vectors through the normalizer under several idle patterns and
// both sum widths, predicts norm and unit vector per item and checks them.
// ---------------------------------------------------------------------------
module tb_fixed_vec3_normalizer;
  timeunit 1ns;
  timeprecision 1ps;
  import fvn_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = DEPTH + 20;

  // idle patterns
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // vec_x, vec_y, vec_z
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // unit_x, unit_y, unit_z, length

  logic [95:0]  vec_pending[$];
  logic [127:0] norm_expected[$];
  logic         wide_mode;
  idle_t        idle_mode;
  int           hold_cycles;
  int           mismatches;
  int           idle_count;

  fixed_vec3_normalizer i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // integer square root of a 64-bit value, bit by bit
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // norm and unit vector of one packed vector
  function automatic logic [127:0] normalize(logic [95:0] v, logic wide);
    logic signed [63:0]  comp[3];
    logic [63:0]         mag;
    logic [63:0]         sum;
    logic [31:0]         len;
    logic signed [63:0]  len_s;
    logic signed [63:0]  recip;
    logic signed [127:0] prod;
    logic [31:0]         unit[3];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      comp[k] = 64'(signed'(v[32*k +: 32]));
      mag = (comp[k] < 0) ? 64'(-comp[k]) : 64'(comp[k]);
      sum += (mag * mag) >> FRAC;
    end
    if (!wide) sum = {32'd0, sum[31:0]};
    len = 32'(int_sqrt(sum) << (FRAC / 2));
    len_s = 64'(signed'(len));
    for (int k = 0; k < 3; k++) begin
      if (len_s == 0) unit[k] = '0;
      else if (len == ONE_FX) unit[k] = v[32*k +: 32];
      else begin
        recip = signed'(DIVIDEND) / len_s;
        recip = 64'(signed'(recip[31:0]));
        prod = 128'(comp[k]) * 128'(recip);
        prod = prod >>> FRAC;
        unit[k] = prod[31:0];
      end
    end
    return {len, unit[2], unit[1], unit[0]};
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
      4: return $urandom() >> $urandom_range(0, 31);
      default: return 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_pending.push_back({z, y, x});
  endtask

  // driver: items predicted at acceptance, head of queue is the offered item
  always @(posedge clk) begin
    if (rst) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        norm_expected.push_back(normalize(in_tdata, wide_mode));
        void'(vec_pending.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // keep offering the same item
      end else if (vec_pending.size() > 0 &&
                   !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 75) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10))) begin
        in_tvalid <= 1'b1;
        in_tdata <= vec_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 75) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10));
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && out_tvalid && out_tready) begin
      if (norm_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", out_tdata);
      end else begin
        want = norm_expected.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (out_tdata[32*f +: 32] !== want[32*f +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h actual %h", f,
                       want[32*f +: 32], out_tdata[32*f +: 32]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (hold_cycles == 0)
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_cfg(logic wide);
    cfg_valid <= 1'b1;
    cfg_data <= wide;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wide_mode = wide;
  endtask

  task automatic wait_drain();
    while (vec_pending.size() != 0 || in_tvalid || norm_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(idle_t mode, int count);
    idle_mode = mode;
    for (int i = 0; i < count; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    wide_mode = 1'b0;
    idle_mode = IDLE_NONE;
    hold_cycles = 0;
    mismatches = 0;
    idle_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, unit norm, extremes, tiny norm, negative norm, wrap
    for (int w = 0; w < 2; w++) begin
      write_cfg(w[0]);
      add_vec(32'd0, 32'd0, 32'd0);
      add_vec(ONE_FX, 32'd0, 32'd0);
      add_vec(32'd0, -ONE_FX, 32'd0);
      add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_vec(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      add_vec(32'd1, 32'd0, 32'd0);
      add_vec(32'd256, 32'd0, 32'd0);
      add_vec(32'hffff_ff00, 32'd3, 32'd5);
      add_vec(32'd3 << FRAC, 32'd4 << FRAC, 32'd0);
      add_vec(32'h0100_0000, 32'h00ff_ffff, 32'hff00_0000);
      add_vec(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
      wait_drain();
    end

    // pressure: long receiver hold-off while the sender keeps going
    idle_mode = IDLE_NONE;
    hold_cycles = 300;
    for (int i = 0; i < 150; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
    wait_drain();

    write_cfg(1'b0);
    run_phase(IDLE_NONE, 250);
    run_phase(IDLE_SEND, 150);
    write_cfg(1'b1);
    run_phase(IDLE_RECV, 250);
    run_phase(IDLE_BOTH, 200);
    write_cfg(1'b0);
    run_phase(IDLE_BOTH, 150);
    run_phase(IDLE_RECV, 100);
    write_cfg(1'b1);
    run_phase(IDLE_NONE, 176);

    if (mismatches == 0 && norm_expected.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
